// ===== src/assert_macros.svh =====
// Assertion macros used by the RTL of the tag store.
// No dependencies; the checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// Expression must never be true at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== src/salru_pkg.sv =====
// Shared constants, types and elaboration helpers of the LRU tag store.
// No dependencies.
package salru_pkg;

	localparam int DEF_SETS         = 1024;
	localparam int DEF_WAYS         = 4;
	localparam int DEF_LINE_BYTES   = 64;
	localparam int DEF_ADDRESS_BITS = 64;

	localparam int ADDR_W  = 64;
	localparam int COUNT_W = 32;

	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [COUNT_W-1:0] count_t;

	// Floor of log2, evaluated on parameters at elaboration.
	function automatic int flog2(input int v);
		int n;
		int x;
		n = 0;
		x = v;
		while (x > 1) begin
			x = x >> 1;
			n = n + 1;
		end
		return n;
	endfunction

endpackage

// ===== src/set_assoc_lru_tag_store_core.sv =====
// Top level of the set-associative, true-LRU tag store with access counters.
// Depends on salru_pkg, assert_macros.svh, salru_store and salru_lru.
//
//  channel  | direction | tdata                          | tuser
//  ---------+-----------+--------------------------------+-------------
//  s_axis   | in        | address[63:0]                  | op (1 store)
//  m_axis   | out       | hit, miss, load hit, load miss | miss
//
// An access transfer is taken into the lookup stage, which reads its set row;
// as it retires, the rank update and write-back of that row are done and the
// result register is loaded: one access per cycle while m_axis does not stall.
// A back-to-back access to the same set reads the row being written through
// the forwarding path of the store, so no bubble is needed.
// After reset the valid bits and ranks of all 2**floor(log2(SETS)) set rows are
// swept to zero, one set per cycle; s_axis_tready stays low meanwhile.
// A stall on m_axis holds an occupied lookup stage, which holds s_axis_tready low.
`include "assert_macros.svh"

module set_assoc_lru_tag_store_core #(
	parameter int SETS         = salru_pkg::DEF_SETS,
	parameter int WAYS         = salru_pkg::DEF_WAYS,
	parameter int LINE_BYTES   = salru_pkg::DEF_LINE_BYTES,
	parameter int ADDRESS_BITS = salru_pkg::DEF_ADDRESS_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  salru_pkg::addr_t                 s_axis_tdata,  // [63:0] address
	input  logic [0:0]                       s_axis_tuser,  // [0] op
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [31:0] hit_total, [63:32] miss_total, [95:64] load_hit_total,
	// [127:96] load_miss_total
	output logic [4*salru_pkg::COUNT_W-1:0]  m_axis_tdata,
	output logic [0:0]                       m_axis_tuser   // [0] miss
);

	import salru_pkg::*;

	// Address split. The line offset and set index take floor(log2) bits.
	localparam int OFF_BITS = flog2(LINE_BYTES);
	localparam int SET_BITS = flog2(SETS);
	localparam int LOW_BITS = OFF_BITS + SET_BITS;
	localparam int ROW_AW   = (SET_BITS > 0) ? SET_BITS : 1;
	localparam int ROWS     = 1 << SET_BITS;
	localparam int TAG_W    = (ADDRESS_BITS > LOW_BITS) ? ADDRESS_BITS - LOW_BITS : 1;
	localparam int RANK_W   = (WAYS > 1) ? $clog2(WAYS) : 1;

	localparam addr_t ADDR_MASK = (ADDRESS_BITS >= ADDR_W) ? '1 :
		((ADDR_W'(1) << ADDRESS_BITS) - ADDR_W'(1));
	localparam addr_t ROW_MASK  = ADDR_W'(ROWS - 1);

	addr_t               addr_masked;
	addr_t               tag_full;
	addr_t               set_full;
	logic [TAG_W-1:0]    in_tag;
	logic [ROW_AW-1:0]   in_set;
	logic                in_fire;

	// Lookup stage: the access whose set row is being read.
	logic                s1_valid_q;
	logic                s1_op_s1;
	logic [TAG_W-1:0]    s1_tag_s1;
	logic [ROW_AW-1:0]   s1_set_s1;
	logic                s1_adv;

	logic [WAYS-1:0]        rd_valid;
	logic [WAYS*RANK_W-1:0] rd_rank;
	logic [WAYS*TAG_W-1:0]  rd_tag;
	logic [WAYS-1:0]        wr_valid;
	logic [WAYS*RANK_W-1:0] wr_rank;
	logic [WAYS*TAG_W-1:0]  wr_tag;
	logic                   lk_miss;
	logic                   clearing;

	// Result register and running totals.
	logic   out_valid_q;
	logic   out_miss_q;
	count_t hit_q;
	count_t miss_q;
	count_t load_hit_q;
	count_t load_miss_q;

	assign addr_masked = s_axis_tdata & ADDR_MASK;
	assign tag_full    = addr_masked >> LOW_BITS;
	assign set_full    = (addr_masked >> OFF_BITS) & ROW_MASK;
	assign in_tag      = tag_full[TAG_W-1:0];
	assign in_set      = set_full[ROW_AW-1:0];

	// The lookup stage retires whenever the result register is free or drains.
	assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !clearing && (!s1_valid_q || s1_adv);
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	salru_store #(
		.WAYS   (WAYS),
		.TAG_W  (TAG_W),
		.RANK_W (RANK_W),
		.ROW_AW (ROW_AW),
		.ROWS   (ROWS)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (in_fire),
		.rd_addr  (in_set),
		.wr_en    (s1_adv),
		.wr_addr  (s1_set_s1),
		.wr_valid (wr_valid),
		.wr_rank  (wr_rank),
		.wr_tag   (wr_tag),
		.rd_valid (rd_valid),
		.rd_rank  (rd_rank),
		.rd_tag   (rd_tag),
		.clearing (clearing)
	);

	salru_lru #(
		.WAYS   (WAYS),
		.TAG_W  (TAG_W),
		.RANK_W (RANK_W)
	) u_lru (
		.tag      (s1_tag_s1),
		.rd_valid (rd_valid),
		.rd_rank  (rd_rank),
		.rd_tag   (rd_tag),
		.miss     (lk_miss),
		.wr_valid (wr_valid),
		.wr_rank  (wr_rank),
		.wr_tag   (wr_tag)
	);

	always_ff @(posedge clk) begin
		if (in_fire) begin
			s1_op_s1  <= s_axis_tuser[0];
			s1_tag_s1 <= in_tag;
			s1_set_s1 <= in_set;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_fire) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	// Totals change only when a lookup retires, which also loads the result
	// register, so the totals on m_axis_tdata belong to the shown result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_miss_q  <= 1'b0;
			hit_q       <= '0;
			miss_q      <= '0;
			load_hit_q  <= '0;
			load_miss_q <= '0;
		end else begin
			if (s1_adv) begin
				out_valid_q <= 1'b1;
				out_miss_q  <= lk_miss;
				if (lk_miss) begin
					if (miss_q != '1) begin
						miss_q <= miss_q + COUNT_W'(1);
					end
					if (!s1_op_s1 && (load_miss_q != '1)) begin
						load_miss_q <= load_miss_q + COUNT_W'(1);
					end
				end else begin
					if (hit_q != '1) begin
						hit_q <= hit_q + COUNT_W'(1);
					end
					if (!s1_op_s1 && (load_hit_q != '1)) begin
						load_hit_q <= load_hit_q + COUNT_W'(1);
					end
				end
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tuser[0] = out_miss_q;
	assign m_axis_tdata    = {load_miss_q, load_hit_q, miss_q, hit_q};

	// Nothing enters while the valid and rank sweep is still running.
	`ASSERT_NEVER(a_no_fire_clearing, clk, arst_n, clearing && in_fire)
	// A retiring lookup always leaves a result waiting on the next edge.
	`ASSERT_CLK(a_retire_shows, clk, arst_n, s1_adv |=> m_axis_tvalid)
	// A retired hit moves the hit total unless it is already saturated.
	`ASSERT_CLK(a_hit_counts, clk, arst_n,
		(s1_adv && !lk_miss) |=> ((hit_q != $past(hit_q)) || (hit_q == '1)))

endmodule

// ===== src/salru_store.sv =====
// Set-row memories of the tag store: tags, plus valid bits and age ranks.
// Holds the post-reset clearing sweep and same-row write-to-read forwarding.
module salru_store #(
	parameter int WAYS   = 4,
	parameter int TAG_W  = 48,
	parameter int RANK_W = 2,
	parameter int ROW_AW = 10,
	parameter int ROWS   = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [ROW_AW-1:0]        rd_addr,
	input  logic                     wr_en,
	input  logic [ROW_AW-1:0]        wr_addr,
	input  logic [WAYS-1:0]          wr_valid,
	input  logic [WAYS*RANK_W-1:0]   wr_rank,
	input  logic [WAYS*TAG_W-1:0]    wr_tag,
	output logic [WAYS-1:0]          rd_valid,
	output logic [WAYS*RANK_W-1:0]   rd_rank,
	output logic [WAYS*TAG_W-1:0]    rd_tag,
	output logic                     clearing
);

	localparam int ST_W = WAYS + WAYS*RANK_W;
	localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROWS - 1);

	logic [ST_W-1:0]       st_mem [ROWS];
	logic [WAYS*TAG_W-1:0] tag_mem [ROWS];

	logic [ST_W-1:0]       st_rd_q;
	logic [WAYS*TAG_W-1:0] tag_rd_q;
	logic [ST_W-1:0]       st_fwd_q;
	logic [WAYS*TAG_W-1:0] tag_fwd_q;
	logic                  fwd_q;
	logic                  clr_q;
	logic [ROW_AW-1:0]     clr_row_q;

	logic                  st_we;
	logic [ROW_AW-1:0]     st_waddr;
	logic [ST_W-1:0]       st_wdata;

	always_comb begin
		if (clr_q) begin
			st_we    = 1'b1;
			st_waddr = clr_row_q;
			st_wdata = '0;
		end else begin
			st_we    = wr_en;
			st_waddr = wr_addr;
			st_wdata = {wr_rank, wr_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			st_mem[st_waddr] <= st_wdata;
		end
		if (rd_en) begin
			st_rd_q <= st_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tag_mem[wr_addr] <= wr_tag;
		end
		if (rd_en) begin
			tag_rd_q <= tag_mem[rd_addr];
		end
	end

	// A read of the row being written in the same cycle takes the new data.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			st_fwd_q  <= {wr_rank, wr_valid};
			tag_fwd_q <= wr_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_row_q <= '0;
		end else if (clr_q) begin
			if (clr_row_q == LAST_ROW) begin
				clr_q <= 1'b0;
			end
			clr_row_q <= clr_row_q + ROW_AW'(1);
		end
	end

	assign rd_valid = fwd_q ? st_fwd_q[WAYS-1:0] : st_rd_q[WAYS-1:0];
	assign rd_rank  = fwd_q ? st_fwd_q[ST_W-1:WAYS] : st_rd_q[ST_W-1:WAYS];
	assign rd_tag   = fwd_q ? tag_fwd_q : tag_rd_q;
	assign clearing = clr_q;

endmodule

// ===== src/salru_lru.sv =====
// Tag compare and true-LRU rank update of one set row.
// Purely combinational; no dependencies.
module salru_lru #(
	parameter int WAYS   = 4,
	parameter int TAG_W  = 48,
	parameter int RANK_W = 2
) (
	input  logic [TAG_W-1:0]         tag,
	input  logic [WAYS-1:0]          rd_valid,
	input  logic [WAYS*RANK_W-1:0]   rd_rank,
	input  logic [WAYS*TAG_W-1:0]    rd_tag,
	output logic                     miss,
	output logic [WAYS-1:0]          wr_valid,
	output logic [WAYS*RANK_W-1:0]   wr_rank,
	output logic [WAYS*TAG_W-1:0]    wr_tag
);

	localparam logic [RANK_W-1:0] OLDEST = RANK_W'(WAYS - 1);

	logic [WAYS-1:0]   hit_vec;
	logic [RANK_W-1:0] hit_way;
	logic [RANK_W-1:0] free_way;
	logic [RANK_W-1:0] old_way;
	logic [RANK_W-1:0] victim;
	logic [RANK_W-1:0] hit_rank;
	logic [RANK_W-1:0] rank_w;
	logic              any_free;

	always_comb begin
		hit_way  = '0;
		free_way = '0;
		old_way  = '0;
		for (int w = 0; w < WAYS; w++) begin
			hit_vec[w] = rd_valid[w] && (rd_tag[w*TAG_W +: TAG_W] == tag);
		end
		// Lowest matching way and lowest invalid way win.
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (hit_vec[w]) begin
				hit_way = RANK_W'(w);
			end
			if (!rd_valid[w]) begin
				free_way = RANK_W'(w);
			end
		end
		// In a full set the ranks are distinct, so exactly one way is oldest.
		for (int w = 0; w < WAYS; w++) begin
			if (rd_rank[w*RANK_W +: RANK_W] == OLDEST) begin
				old_way = RANK_W'(w);
			end
		end
		any_free = !(&rd_valid);
		miss     = !(|hit_vec);
		victim   = any_free ? free_way : old_way;
		hit_rank = rd_rank[hit_way*RANK_W +: RANK_W];

		wr_valid = rd_valid;
		wr_tag   = rd_tag;
		for (int w = 0; w < WAYS; w++) begin
			rank_w = rd_rank[w*RANK_W +: RANK_W];
			if (!miss) begin
				if (RANK_W'(w) == hit_way) begin
					wr_rank[w*RANK_W +: RANK_W] = '0;
				end else if (rd_valid[w] && (rank_w < hit_rank)) begin
					wr_rank[w*RANK_W +: RANK_W] = rank_w + RANK_W'(1);
				end else begin
					wr_rank[w*RANK_W +: RANK_W] = rank_w;
				end
			end else begin
				if (RANK_W'(w) == victim) begin
					wr_rank[w*RANK_W +: RANK_W] = '0;
					wr_valid[w]                 = 1'b1;
					wr_tag[w*TAG_W +: TAG_W]    = tag;
				end else if (rd_valid[w]) begin
					wr_rank[w*RANK_W +: RANK_W] = rank_w + RANK_W'(1);
				end else begin
					wr_rank[w*RANK_W +: RANK_W] = rank_w;
				end
			end
		end
	end

endmodule
